// File: rtl/nid_pkg.sv
// ----------------------------------------------------------------------------
// nid_pkg
// Shared types, constants and window helper for the NEC IR edge decoder.
// ----------------------------------------------------------------------------
package nid_pkg;

	// Timestamp width and frame length
	localparam int TIME_BITS  = 32;
	localparam int FRAME_BITS = 32;
	localparam int IDX_BITS   = $clog2(FRAME_BITS + 1);
	localparam int CMP_BITS   = (TIME_BITS > 17) ? TIME_BITS : 17;

	// Command byte position inside the frame
	localparam int CMD_FIRST_BIT = 16;
	localparam int CMD_LAST_BIT  = 24;

	// Configuration register indexes
	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_START_LEN  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT_LEN = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_ZERO_LEN   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_ONE_LEN    = 3'd4;

	// Register reset values
	localparam logic [15:0] TOLERANCE_RST  = 16'd300;
	localparam logic [15:0] START_LEN_RST  = 16'd13500;
	localparam logic [15:0] REPEAT_LEN_RST = 16'd11250;
	localparam logic [15:0] ZERO_LEN_RST   = 16'd1125;
	localparam logic [15:0] ONE_LEN_RST    = 16'd2250;

	// Decoder phases (code 3 is unused and behaves as waiting)
	localparam logic [1:0] PH_READING = 2'd0;
	localparam logic [1:0] PH_WAITING = 2'd1;
	localparam logic [1:0] PH_COMING  = 2'd2;

	typedef struct packed {
		logic [15:0] tolerance_us;
		logic [15:0] start_len_us;
		logic [15:0] repeat_len_us;
		logic [15:0] zero_len_us;
		logic [15:0] one_len_us;
	} cfg_t;

	// Window hits of one edge interval
	typedef struct packed {
		logic start_hit;
		logic repeat_hit;
		logic zero_hit;
		logic one_hit;
	} class_t;

	typedef struct packed {
		logic [7:0] command_byte;
		logic       repeat_seen;
		logic       frame_end;
		logic       bit_error;
	} result_t;

	// Open window (nominal - tol, nominal + tol), low bound floored at zero
	function automatic logic in_window(input logic [TIME_BITS-1:0] len,
	                                   input logic [15:0] nominal,
	                                   input logic [15:0] tol);
		logic [15:0]         lo;
		logic [16:0]         hi;
		logic [CMP_BITS-1:0] len_x;
		logic [CMP_BITS-1:0] lo_x;
		logic [CMP_BITS-1:0] hi_x;
		lo    = (nominal > tol) ? (nominal - tol) : 16'd0;
		hi    = {1'b0, nominal} + {1'b0, tol};
		len_x = CMP_BITS'(len);
		lo_x  = CMP_BITS'(lo);
		hi_x  = CMP_BITS'(hi);
		return (len_x > lo_x) && (len_x < hi_x);
	endfunction

endpackage

// File: rtl/nec_ir_pulse_distance_decoder_top.sv
// ----------------------------------------------------------------------------
// nec_ir_pulse_distance_decoder_top
// Path: edge -> window compare -> hit queue -> state machine -> output queue.
// Throughput: one request per cycle while not full; the compare runs in the
//   accept cycle; the state machine takes one per cycle unless the output is full.
// Reset: queues empty, phase waiting, registers at their nominal defaults.
// ----------------------------------------------------------------------------
module nec_ir_pulse_distance_decoder_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [31:0]                      edge_time_us,
	output logic                             empty,
	input  logic                             pop,
	output logic [7:0]                       command_byte,
	output logic                             repeat_seen,
	output logic                             frame_end,
	output logic                             bit_error,
	input  logic                             cfg_we,
	input  logic [nid_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [15:0]                      cfg_wdata
);
	import nid_pkg::*;

	logic    cls_valid;
	logic    cls_pop;
	class_t  cls;
	result_t res;

	// Interval measure and window classification
	nid_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.edge_time_us (edge_time_us),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.cls_valid    (cls_valid),
		.cls          (cls),
		.cls_pop      (cls_pop)
	);

	// Frame state machine and result queue
	nid_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_valid (cls_valid),
		.cls       (cls),
		.cls_pop   (cls_pop),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign command_byte = res.command_byte;
	assign repeat_seen  = res.repeat_seen;
	assign frame_end    = res.frame_end;
	assign bit_error    = res.bit_error;

endmodule

// File: rtl/nid_front.sv
// ----------------------------------------------------------------------------
// nid_front
// Holds configuration, measures edge intervals, classifies them against the
// four windows and queues the window hits for the back end.
// ----------------------------------------------------------------------------
module nid_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [31:0]                        edge_time_us,
	input  logic                               cfg_we,
	input  logic [nid_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [15:0]                        cfg_wdata,
	output logic                               cls_valid,
	output nid_pkg::class_t                    cls,
	input  logic                               cls_pop
);
	import nid_pkg::*;

	cfg_t                 cfg_q;
	logic [TIME_BITS-1:0] last_q;
	logic [TIME_BITS-1:0] now;
	logic [TIME_BITS-1:0] len;
	class_t               cls_new;
	class_t               queue_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;
	logic                 accept;
	logic                 take;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tolerance_us  <= TOLERANCE_RST;
			cfg_q.start_len_us  <= START_LEN_RST;
			cfg_q.repeat_len_us <= REPEAT_LEN_RST;
			cfg_q.zero_len_us   <= ZERO_LEN_RST;
			cfg_q.one_len_us    <= ONE_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOLERANCE:  cfg_q.tolerance_us  <= cfg_wdata;
				REG_START_LEN:  cfg_q.start_len_us  <= cfg_wdata;
				REG_REPEAT_LEN: cfg_q.repeat_len_us <= cfg_wdata;
				REG_ZERO_LEN:   cfg_q.zero_len_us   <= cfg_wdata;
				REG_ONE_LEN:    cfg_q.one_len_us    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Interval since the previous edge, wrapping
	assign now = TIME_BITS'(edge_time_us);
	assign len = now - last_q;

	always_comb begin
		cls_new.start_hit  = in_window(len, cfg_q.start_len_us,  cfg_q.tolerance_us);
		cls_new.repeat_hit = in_window(len, cfg_q.repeat_len_us, cfg_q.tolerance_us);
		cls_new.zero_hit   = in_window(len, cfg_q.zero_len_us,   cfg_q.tolerance_us);
		cls_new.one_hit    = in_window(len, cfg_q.one_len_us,    cfg_q.tolerance_us);
	end

	assign full   = (count_q == 2'd2);
	assign accept = push && !full;
	assign take   = cls_pop && cls_valid;

	// Every phase records the edge time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (accept) begin
			last_q <= now;
		end
	end

	// Two-entry queue of window hits
	always_ff @(posedge clk) begin
		if (accept) begin
			queue_q[wr_ptr_q] <= cls_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (accept) wr_ptr_q <= !wr_ptr_q;
			if (take)   rd_ptr_q <= !rd_ptr_q;
			case ({accept, take})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign cls_valid = (count_q != 2'd0);
	assign cls       = queue_q[rd_ptr_q];

endmodule

// File: rtl/nid_back.sv
// ----------------------------------------------------------------------------
// nid_back
// Runs the frame state machine on queued window hits and holds the results
// in a two-entry output queue.
// ----------------------------------------------------------------------------
module nid_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cls_valid,
	input  nid_pkg::class_t cls,
	output logic            cls_pop,
	output logic            empty,
	input  logic            pop,
	output nid_pkg::result_t res
);
	import nid_pkg::*;

	logic [1:0]          phase_q;
	logic [IDX_BITS-1:0] bit_index_q;
	logic [7:0]          captured_q;
	logic                repeat_q;

	logic [1:0]          phase_d;
	logic [IDX_BITS-1:0] bit_index_d;
	logic [7:0]          captured_d;
	logic                repeat_d;
	logic                frame_end;
	logic                bit_error;
	logic [2:0]          bit_sel;
	result_t             res_new;

	result_t             queue_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          count_q;
	logic                out_full;
	logic                out_take;
	logic                step;

	assign out_full = (count_q == 2'd2);
	assign step     = cls_valid && !out_full;
	assign cls_pop  = step;
	assign bit_sel  = 3'(bit_index_q - IDX_BITS'(CMD_FIRST_BIT));

	// Next state for one edge
	always_comb begin
		phase_d     = phase_q;
		bit_index_d = bit_index_q;
		captured_d  = captured_q;
		repeat_d    = repeat_q;
		frame_end   = 1'b0;
		bit_error   = 1'b0;
		case (phase_q)
			PH_COMING: begin
				if (cls.start_hit) begin
					bit_index_d = '0;
					repeat_d    = 1'b0;
					phase_d     = PH_READING;
				end else if (cls.repeat_hit) begin
					repeat_d = 1'b1;
					phase_d  = PH_WAITING;
				end
			end
			PH_READING: begin
				if (bit_index_q < IDX_BITS'(FRAME_BITS)) begin
					if (!cls.zero_hit && !cls.one_hit) begin
						bit_error = 1'b1;
					end else begin
						if (bit_index_q inside {[CMD_FIRST_BIT:CMD_LAST_BIT-1]}) begin
							captured_d[bit_sel] = !cls.zero_hit;
						end
						bit_index_d = bit_index_q + IDX_BITS'(1);
					end
				end else begin
					frame_end   = 1'b1;
					bit_index_d = '0;
					phase_d     = PH_WAITING;
				end
			end
			default: begin
				phase_d = PH_COMING;
			end
		endcase
		res_new.command_byte = captured_d;
		res_new.repeat_seen  = repeat_d;
		res_new.frame_end    = frame_end;
		res_new.bit_error    = bit_error;
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAITING;
			bit_index_q <= '0;
			captured_q  <= '0;
			repeat_q    <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			bit_index_q <= bit_index_d;
			captured_q  <= captured_d;
			repeat_q    <= repeat_d;
		end
	end

	// Output queue
	assign out_take = pop && !empty;

	always_ff @(posedge clk) begin
		if (step) begin
			queue_q[wr_ptr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (step)     wr_ptr_q <= !wr_ptr_q;
			if (out_take) rd_ptr_q <= !rd_ptr_q;
			case ({step, out_take})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign empty = (count_q == 2'd0);
	assign res   = queue_q[rd_ptr_q];

endmodule
